[rtl/core/byte_stuffing_framer_xor_unit_defines.svh]
// assertion helpers for the framer, clocked on clk and muted during reset
`ifndef BYTE_STUFFING_FRAMER_XOR_UNIT_DEFINES_SVH
`define BYTE_STUFFING_FRAMER_XOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BSF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer assertion failed");

// next-cycle implication
`define BSF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`endif

[rtl/core/bsf_pkg.sv]
package bsf_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [7:0] TERM_BYTE = 8'h0A;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // line byte steps of one item, sent lowest first
  localparam int STEP_FLAG = 0;
  localparam int STEP_ESC  = 1;
  localparam int STEP_DATA = 2;
  localparam int STEP_CSUM = 3;
  localparam int STEP_TERM = 4;
  localparam int NSTEPS    = 5;

  typedef logic [NSTEPS-1:0] step_mask_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] csum;
    logic       first;
    logic       esc;
    logic       last;
  } desc_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/core/bsf_front.sv]
module bsf_front
  import bsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  q_stat_t  q_stat,
  output logic     q_push,
  output desc_t    q_wdata
);

  logic [7:0] xor_r;
  logic [7:0] xor_nxt;
  logic [7:0] csum;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  // a first byte restarts the checksum before folding in
  assign csum = (in_item.first_byte ? 8'h00 : xor_r) ^ in_item.data_byte;

  always_comb begin
    q_wdata.raw   = in_item.data_byte;
    q_wdata.csum  = csum;
    q_wdata.first = in_item.first_byte;
    q_wdata.esc   = (in_item.data_byte == ESC_BYTE) || (in_item.data_byte == FLAG_BYTE);
    q_wdata.last  = in_item.last_byte;
  end

  always_comb begin
    xor_nxt = xor_r;
    if (q_push) begin
      xor_nxt = in_item.last_byte ? 8'h00 : csum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_r <= 8'h00;
    end else begin
      xor_r <= xor_nxt;
    end
  end

endmodule

[rtl/core/bsf_queue.sv]
module bsf_queue
  import bsf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  desc_t   wdata,
  input  logic    pop,
  output desc_t   rdata,
  output q_stat_t stat
);

  desc_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;
  logic [QAW-1:0] wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_nxt;
  logic [QAW:0]   count_nxt;
  logic           do_push;
  logic           do_pop;

  assign stat.full  = (count_r == (QAW+1)'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/core/bsf_back.sv]
`include "byte_stuffing_framer_xor_unit_defines.svh"

module bsf_back
  import bsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  desc_t     q_rdata,
  input  q_stat_t   q_stat,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  desc_t      cur_r;
  desc_t      cur_nxt;
  step_mask_t mask_r;
  step_mask_t mask_nxt;
  step_mask_t low;
  step_mask_t rem;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_item_r;
  out_item_t  out_item_nxt;
  logic       adv;
  logic [7:0] sel_byte;

  assign adv = !out_valid_r || !out_stall;
  assign low = mask_r & (~mask_r + 1'b1);
  assign rem = mask_r & ~low;

  always_comb begin
    unique case (low)
      step_mask_t'(1) << STEP_FLAG: sel_byte = FLAG_BYTE;
      step_mask_t'(1) << STEP_ESC:  sel_byte = ESC_BYTE;
      step_mask_t'(1) << STEP_DATA: sel_byte = cur_r.raw ^ (cur_r.esc ? ESC_XOR : 8'h00);
      step_mask_t'(1) << STEP_CSUM: sel_byte = cur_r.csum;
      step_mask_t'(1) << STEP_TERM: sel_byte = TERM_BYTE;
      default:                      sel_byte = 8'h00;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    cur_nxt       = cur_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (adv) begin
      out_valid_nxt = 1'b0;
      if (mask_r != '0) begin
        out_valid_nxt          = 1'b1;
        out_item_nxt.line_byte = sel_byte;
        out_item_nxt.run_last  = (rem == '0);
        out_item_nxt.frame_end = low[STEP_TERM];
        mask_nxt               = rem;
      end
      // reload as the last step goes out, so bytes flow without a gap
      if (((mask_r == '0) || (rem == '0)) && !q_stat.empty) begin
        q_pop                = 1'b1;
        cur_nxt              = q_rdata;
        mask_nxt             = '0;
        mask_nxt[STEP_FLAG]  = q_rdata.first;
        mask_nxt[STEP_ESC]   = q_rdata.esc;
        mask_nxt[STEP_DATA]  = 1'b1;
        mask_nxt[STEP_CSUM]  = q_rdata.last;
        mask_nxt[STEP_TERM]  = q_rdata.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `BSF_ASSERT_IMP(a_term_closes, out_valid_r && out_item_r.frame_end, (out_item_r.line_byte == TERM_BYTE) && out_item_r.run_last)
  `BSF_ASSERT_IMP(a_data_after_prefix, mask_r[STEP_FLAG] || mask_r[STEP_ESC], mask_r[STEP_DATA])
  `BSF_ASSERT_NXT(a_drain_idle, out_valid_r && !out_stall && (mask_r == '0) && q_stat.empty, !out_valid_r)

endmodule

[rtl/core/byte_stuffing_framer_xor_unit.sv]
// byte stuffing framer with xor checksum
// in channel: one raw payload item per handshake (in_valid, in_stall, in_item)
//   with first/last frame marks; an item is taken when in_valid is high and
//   in_stall is low
// out channel: one line byte per handshake (out_valid, out_stall, out_item);
//   run_last marks the final byte of an item, frame_end the 0x0a terminator
// each item expands to 1 to 5 line bytes: optional flag, optional escape,
//   the data byte, then checksum and terminator after a last byte
// throughput: one line byte per cycle from the back sequencer while the
//   receiver is not stalling and the queue holds items
// an accepted item is written into a queue entry, then its first byte is
//   loaded into the output register when the receiver is not stalling
// a four-entry queue parts the front from the back, so items keep being
//   taken while the back works through long expansions or is stalled
// when the receiver stalls, the output register holds its byte; the queue
//   fills and in_stall rises once it is full
// reset (synchronous, rst_n low) empties the queue, drops any pending byte
//   and clears the running checksum
module byte_stuffing_framer_xor_unit
  import bsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // front to queue
  logic    q_push;
  desc_t   q_wdata;
  // queue to back
  logic    q_pop;
  desc_t   q_rdata;
  q_stat_t q_stat;

  // classify, escape check and checksum fold
  bsf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // short decoupling queue of classified items
  bsf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // byte sequencer with registered output
  bsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[bench/testbench.sv]
module testbench;
  import bsf_pkg::*;

  // clock, reset and the two channels
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // line bytes still due from the block, oldest first
  out_item_t line_bytes_due[$];

  // running xor of the open frame, as the block should hold it
  logic [7:0] frame_xor = 8'h00;

  int err_cnt = 0;

  // sender pacing: bursts of items split by random gaps
  int burst_left = 0;
  bit steady = 1'b0;

  // receiver: a stall pattern of its own plus an occasional long hold-off
  logic hold_ask = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   stall_level = 0;
  int   pat_left = 0;

  // watchdog on cycles with no item moving on either channel
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  int idle_cnt = 0;

  byte_stuffing_framer_xor_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // expand one accepted item into the line bytes it should cause
  task automatic stuff_item(input in_item_t it);
    out_item_t parts[NSTEPS];
    int n;
    n = 0;
    // a first mark opens a new frame: flag out, checksum restarts
    if (it.first_byte) begin
      frame_xor = 8'h00;
      parts[n] = '{line_byte: FLAG_BYTE, run_last: 1'b0, frame_end: 1'b0};
      n++;
    end
    frame_xor = frame_xor ^ it.data_byte;
    // flag and escape values are escaped, everything else passes through
    if (it.data_byte == ESC_BYTE || it.data_byte == FLAG_BYTE) begin
      parts[n] = '{line_byte: ESC_BYTE, run_last: 1'b0, frame_end: 1'b0};
      n++;
      parts[n] = '{line_byte: it.data_byte ^ ESC_XOR, run_last: 1'b0, frame_end: 1'b0};
      n++;
    end else begin
      parts[n] = '{line_byte: it.data_byte, run_last: 1'b0, frame_end: 1'b0};
      n++;
    end
    // trailer: checksum goes out raw, even when it looks like a flag
    if (it.last_byte) begin
      parts[n] = '{line_byte: frame_xor, run_last: 1'b0, frame_end: 1'b0};
      n++;
      parts[n] = '{line_byte: TERM_BYTE, run_last: 1'b0, frame_end: 1'b1};
      n++;
      frame_xor = 8'h00;
    end
    parts[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) line_bytes_due.push_back(parts[i]);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_cnt < 20)
      $display("mismatch on %s: got %0h, wanted %0h", what, got, want);
    err_cnt++;
  endtask

  // send one item, idling first if the current burst is used up
  task automatic send_item(input in_item_t it);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        // idle payload is junk, the block must ignore it
        in_valid <= 1'b0;
        in_item <= in_item_t'($urandom);
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left != 0) burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    // hold the item until an edge sees no stall
    do @(posedge clk); while (in_stall);
    stuff_item(it);
  endtask

  function automatic in_item_t mk(input logic [7:0] d, input logic f, input logic l);
    mk = '{data_byte: d, first_byte: f, last_byte: l};
  endfunction

  // payload bias towards the escape, flag and terminator values
  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 9))
      0: pick_data = ESC_BYTE;
      1: pick_data = FLAG_BYTE;
      2: pick_data = TERM_BYTE;
      default: pick_data = 8'($urandom_range(0, 255));
    endcase
  endfunction

  // all-zero and all-one payload, each as a one-byte frame
  task automatic test_field_extremes();
    send_item(mk(8'h00, 1'b1, 1'b1));
    send_item(mk(8'hFF, 1'b1, 1'b1));
  endtask

  // escaped bytes mid-frame and checksums that land on flag or escape values
  task automatic test_escapes();
    send_item(mk(FLAG_BYTE, 1'b1, 1'b0));
    send_item(mk(ESC_BYTE, 1'b0, 1'b0));
    send_item(mk(8'h55, 1'b0, 1'b0));
    send_item(mk(8'hAA, 1'b0, 1'b1));
    // both marks on an escaped byte: five line bytes, checksum is a flag
    send_item(mk(FLAG_BYTE, 1'b1, 1'b1));
    send_item(mk(ESC_BYTE, 1'b1, 1'b1));
    // two bytes whose xor is the flag value
    send_item(mk(8'h70, 1'b1, 1'b0));
    send_item(mk(8'h0E, 1'b0, 1'b1));
  endtask

  // a first mark inside an open frame restarts it with no trailer
  task automatic test_reopen();
    send_item(mk(8'h11, 1'b1, 1'b0));
    send_item(mk(8'h22, 1'b0, 1'b0));
    send_item(mk(8'h33, 1'b1, 1'b0));
    send_item(mk(8'h44, 1'b0, 1'b1));
  endtask

  // bytes with no frame open still get stuffed and summed, no flag
  task automatic test_orphan_bytes();
    send_item(mk(8'h5A, 1'b0, 1'b0));
    send_item(mk(ESC_BYTE, 1'b0, 1'b0));
    send_item(mk(8'h66, 1'b0, 1'b1));
  endtask

  // mostly well-formed frames of random content, some with random marks
  task automatic test_random_frames(input int count);
    int sent;
    int len;
    bit tidy;
    in_item_t it;
    sent = 0;
    while (sent < count) begin
      tidy = ($urandom_range(0, 99) < 85);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 4);
      if (len > count - sent) len = count - sent;
      for (int i = 0; i < len; i++) begin
        it.data_byte = pick_data();
        if (tidy) begin
          it.first_byte = (i == 0);
          it.last_byte = (i == len - 1);
        end else begin
          it.first_byte = 1'($urandom_range(0, 1));
          it.last_byte = 1'($urandom_range(0, 1));
        end
        send_item(it);
        sent++;
      end
    end
  endtask

  // receiver holds off while items keep coming, so the queue fills up
  task automatic test_back_pressure();
    steady = 1'b1;
    hold_ask <= ~hold_ask;
    for (int i = 0; i < 16; i++)
      send_item(mk(pick_data(), i % 4 == 0, i % 4 == 3));
    steady = 1'b0;
    burst_left = 0;
  endtask

  // receiver stall: a long hold on request, else a pattern re-drawn when its random run runs out
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (pat_left == 0) begin
        stall_level <= $urandom_range(0, 3);
        pat_left <= $urandom_range(20, 80);
      end else begin
        pat_left <= pat_left - 1;
      end
      out_stall <= ($urandom_range(0, 3) < stall_level);
    end
  end

  // compare each line byte against the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (line_bytes_due.size() == 0) begin
        report_mismatch("unexpected line byte", out_item.line_byte, 0);
      end else begin
        if (out_item.line_byte !== line_bytes_due[0].line_byte)
          report_mismatch("line_byte", out_item.line_byte, line_bytes_due[0].line_byte);
        if (out_item.run_last !== line_bytes_due[0].run_last)
          report_mismatch("run_last", out_item.run_last, line_bytes_due[0].run_last);
        if (out_item.frame_end !== line_bytes_due[0].frame_end)
          report_mismatch("frame_end", out_item.frame_end, line_bytes_due[0].frame_end);
        void'(line_bytes_due.pop_front());
      end
    end
  end

  // watchdog: too long with nothing moving means the block has hung
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cnt <= 0;
      end else if (idle_cnt >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_escapes();
    test_reopen();
    test_orphan_bytes();
    test_random_frames(32);
    test_back_pressure();
    test_random_frames(32);
    in_valid <= 1'b0;
    // drain, then wait DRAIN_CYCLES more to catch stray bytes
    while (line_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && line_bytes_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
